FILE: rtl/core/irpwc_pkg.sv
package irpwc_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DurW   = 16;
  localparam int unsigned UnitW  = 8;
  localparam int unsigned ResW   = 8;

  // The dividend is a 16-bit duration plus half the resolution.
  localparam int unsigned NumW   = DurW + 1;
  localparam int unsigned StepW  = $clog2(NumW + 1);

  localparam int unsigned BufferDepthDefault = 32;
  localparam logic [ResW-1:0] ResolutionReset = 8'd50;

  localparam logic FuncSample = 1'b0;
  localparam logic FuncDrain  = 1'b1;

  typedef struct packed {
    logic             func;
    logic             pin_level;
    logic [TimeW-1:0] time_us;
  } in_item_t;

  typedef struct packed {
    logic [DurW-1:0] high_time_us;
    logic [DurW-1:0] low_time_us;
    logic            was_full;
    logic            last;
  } res_item_t;

endpackage

FILE: rtl/core/irpwc_if.sv
interface irpwc_in_if;
  import irpwc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface irpwc_res_if;
  import irpwc_pkg::*;

  logic      valid;
  logic      ready;
  res_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface irpwc_cfg_if;
  import irpwc_pkg::*;

  logic            valid;
  logic            ready;
  logic [ResW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/ir_pulse_width_capture_core.sv
// Pulse-width capture for a remote-control receiver pin. Sample items carry the
// pin level and a microsecond timestamp; each level change is measured, rounded
// to units of the resolution register by a 17-step serial divider and kept in a
// pair memory of BUFFER_DEPTH entries. A sample at an unchanged level, or a
// rising edge that finds the memory full, is handled without the divider; any other sample
// runs the divider before the next item is taken. A drain item reads each
// stored pair from the memory and then moves it into the output register,
// where it waits while the sink stalls. The next item is taken while the last
// pair of a drain still waits in the output register. The resolution register
// may be written at any time the block is idle and resets to 50.
module ir_pulse_width_capture_core #(
  parameter int unsigned BUFFER_DEPTH = irpwc_pkg::BufferDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  irpwc_in_if.sink           in_i,
  irpwc_res_if.source        res_o,
  irpwc_cfg_if.sink          cfg_i
);
  import irpwc_pkg::*;

  localparam int unsigned CntW  = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned AddrW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StRd   = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]            st_q, st_d;
  logic [ResW-1:0]       res_q;
  logic                  prev_level_q;
  logic [TimeW-1:0]      prev_time_q;
  logic [UnitW-1:0]      held_q, held_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       idx_q, idx_d;
  logic                  full_q, full_d;
  logic                  rise_q, rise_d;
  logic [StepW-1:0]      step_q, step_d;
  logic [NumW-1:0]       num_q, num_d;
  logic [UnitW-1:0]      rem_q, rem_d;
  logic                  out_valid_q, out_valid_d;
  res_item_t             out_q, out_d;

  logic [2*UnitW-1:0]    mem [BUFFER_DEPTH];
  logic [2*UnitW-1:0]    rd_data_q;
  logic                  mem_we;

  logic                  in_acc;
  logic                  edge_seen;
  logic [DurW-1:0]       dur;
  logic [ResW-1:0]       divisor;
  logic [UnitW:0]        trial;
  logic                  qbit;
  logic [UnitW-1:0]      units;
  logic                  buf_full;
  logic                  slot_free;
  logic                  last_pair;

  assign in_i.ready  = (st_q == StIdle);
  // The divider and the drain both use the resolution, so it only changes when idle.
  assign cfg_i.ready = (st_q == StIdle);
  assign in_acc      = in_i.valid && in_i.ready;
  assign edge_seen   = (in_i.item.pin_level != prev_level_q);
  assign buf_full    = (count_q == CntW'(BUFFER_DEPTH));

  // A wrapped timer measures one microsecond short, as the elapsed-time rule
  // subtracts from all ones rather than from two to the 32.
  assign dur = in_i.item.time_us[DurW-1:0] - prev_time_q[DurW-1:0]
             - DurW'(in_i.item.time_us < prev_time_q);

  assign divisor = (res_q == '0) ? ResW'(1) : res_q;

  // One restoring division step per cycle, quotient bits shift in at the bottom.
  assign trial = {rem_q, num_q[NumW-1]};
  assign qbit  = (trial >= {1'b0, divisor});
  assign units = num_d[UnitW-1:0];

  assign slot_free = !out_valid_q || res_o.ready;
  assign last_pair = ((idx_q + CntW'(1)) == count_q);

  assign res_o.valid = out_valid_q;
  assign res_o.item  = out_q;

  always_comb begin
    st_d        = st_q;
    held_d      = held_q;
    count_d     = count_q;
    idx_d       = idx_q;
    full_d      = full_q;
    rise_d      = rise_q;
    step_d      = step_q;
    num_d       = {num_q[NumW-2:0], qbit};
    rem_d       = qbit ? UnitW'(trial - {1'b0, divisor}) : trial[UnitW-1:0];
    out_valid_d = out_valid_q && !res_o.ready;
    out_d       = out_q;
    mem_we      = 1'b0;

    case (st_q)
      StIdle: begin
        num_d = NumW'(dur) + NumW'(res_q >> 1);
        rem_d = '0;
        if (in_acc) begin
          if (in_i.item.func == FuncDrain) begin
            idx_d  = '0;
            full_d = buf_full;
            if (count_q != '0) begin
              st_d = StRd;
            end
          end else if (edge_seen && !(in_i.item.pin_level && buf_full)) begin
            rise_d = in_i.item.pin_level;
            step_d = StepW'(NumW);
            st_d   = StDiv;
          end
        end
      end
      StDiv: begin
        step_d = step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          if (rise_q) begin
            mem_we  = 1'b1;
            count_d = count_q + CntW'(1);
          end else begin
            held_d = units;
          end
          st_d = StIdle;
        end
      end
      StRd: begin
        st_d = StOut;
      end
      StOut: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d.high_time_us = {{(DurW-UnitW){1'b0}}, rd_data_q[2*UnitW-1:UnitW]}
                             * {{(DurW-ResW){1'b0}}, res_q};
          out_d.low_time_us  = {{(DurW-UnitW){1'b0}}, rd_data_q[UnitW-1:0]}
                             * {{(DurW-ResW){1'b0}}, res_q};
          out_d.was_full = full_q;
          out_d.last     = last_pair;
          idx_d          = idx_q + CntW'(1);
          if (last_pair) begin
            count_d = '0;
            st_d    = StIdle;
          end else begin
            st_d = StRd;
          end
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= StIdle;
      res_q        <= ResolutionReset;
      prev_level_q <= 1'b0;
      prev_time_q  <= '0;
      held_q       <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      full_q       <= 1'b0;
      rise_q       <= 1'b0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      st_q        <= st_d;
      held_q      <= held_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      full_q      <= full_d;
      rise_q      <= rise_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        res_q <= cfg_i.data;
      end
      if (in_acc && (in_i.item.func == FuncSample) && edge_seen) begin
        prev_level_q <= in_i.item.pin_level;
        prev_time_q  <= in_i.item.time_us;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    out_q <= out_d;
  end

  // Pair memory: one write port for captured pairs, one registered read port
  // for the drain. The state machine never overlaps the two.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[AddrW-1:0]] <= {held_q, units};
    end
    rd_data_q <= mem[idx_q[AddrW-1:0]];
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(BUFFER_DEPTH))
    else $error("pair count beyond buffer depth");

  a_div_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StDiv) |-> (step_q != '0))
    else $error("divider running with no steps left");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StOut && slot_free && last_pair) |=> (count_q == '0 && out_q.last))
    else $error("drain did not empty the buffer on its last item");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(st_q) == StOut))
    else $error("result item raised outside the drain output state");

  a_no_write_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StRd || st_q == StOut) |-> !mem_we)
    else $error("pair memory written during a drain");

endmodule
